@@ rtl/core/sjf_scheduler_table_defines.svh @@
// Assertion macros used by the scheduler datapath.
`ifndef SJF_SCHEDULER_TABLE_DEFINES_SVH
`define SJF_SCHEDULER_TABLE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SJFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SJFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sjft_pkg.sv @@
package sjft_pkg;

	localparam int TIME_W  = 16;
	localparam int CLOCK_W = 32;
	localparam int LEFT_W  = 5;

	// Item function codes
	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_RUN = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_RAN   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic              func;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] burst_time;
	} sjft_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [TIME_W-1:0]  ran_arrival;
		logic [TIME_W-1:0]  ran_burst;
		logic [CLOCK_W-1:0] finish_time;
		logic [LEFT_W-1:0]  jobs_left;
	} sjft_out_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic clr_scan;
		logic step;
		logic commit;
	} sjft_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic func_run;
		logic full;
		logic empty;
		logic slot_free;
		logic idx_last;
		logic out_busy;
	} sjft_sts_t;

endpackage

@@ rtl/core/sjf_scheduler_table.sv @@
// Sequence: a run beat reads the job store one slot per cycle, then passes one compare
// stage and a commit. An add scans from slot 0 for a free slot and then commits; a full
// add or an empty run goes from the check straight to commit. The commit waits while the
// result output is stalled.
// Throughput: one beat at a time; the next beat is taken in the cycle after commit.
// Reset: arst_n clears the valid bits, job count, clock and control; the store is not cleared.
module sjf_scheduler_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_stall,
	input  sjft_pkg::sjft_in_t  job,
	output logic                res_valid,
	input  logic                res_stall,
	output sjft_pkg::sjft_out_t res
);

	import sjft_pkg::*;

	sjft_cmd_t cmd;
	sjft_sts_t sts;

	// Sequencer
	sjft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Job table, scan compare and result register
	sjft_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.cmd      (cmd),
		.sts      (sts),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

@@ rtl/core/sjft_ram.sv @@
module sjft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/sjft_dpath.sv @@
`include "sjf_scheduler_table_defines.svh"

module sjft_dpath #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sjft_pkg::sjft_in_t job,
	input  sjft_pkg::sjft_cmd_t cmd,
	output sjft_pkg::sjft_sts_t sts,
	output logic               res_valid,
	input  logic               res_stall,
	output sjft_pkg::sjft_out_t res
);

	import sjft_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = 2 * TIME_W;

	// Captured item
	logic              func_q;
	logic [TIME_W-1:0] arr_q;
	logic [TIME_W-1:0] bur_q;

	// Table state
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CLOCK_W-1:0]     clock_q;
	logic [IDX_W-1:0]       idx_q;

	// Scan read stage
	logic              cmp_en_s1;
	logic              cmp_v_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [ENT_W-1:0]  rd_data;
	logic [TIME_W-1:0] c_arr;
	logic [TIME_W-1:0] c_bur;

	// Best candidates
	logic              e_found_q;
	logic [TIME_W-1:0] e_arr_q;
	logic [TIME_W-1:0] e_bur_q;
	logic [IDX_W-1:0]  e_idx_q;
	logic              s_found_q;
	logic [TIME_W-1:0] s_arr_q;
	logic [TIME_W-1:0] s_bur_q;
	logic [IDX_W-1:0]  s_idx_q;

	logic              arrived;
	logic              e_better;
	logic              s_better;

	// Commit logic
	logic               full;
	logic               empty;
	logic               do_add;
	logic               do_run;
	logic               use_s;
	logic [TIME_W-1:0]  pick_arr;
	logic [TIME_W-1:0]  pick_bur;
	logic [IDX_W-1:0]   pick_idx;
	logic [CLOCK_W-1:0] sum_base;
	logic [CLOCK_W:0]   sum_full;
	logic [CLOCK_W-1:0] new_clock;
	logic [CNT_W-1:0]   cnt_next;
	logic [31:0]        cnt_ext;
	logic               out_busy;
	sjft_out_t          res_q;
	logic               res_valid_q;

	assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign out_busy = res_valid_q && res_stall;
	assign do_add   = cmd.commit && (func_q == FUNC_ADD) && !full;
	assign do_run   = cmd.commit && (func_q == FUNC_RUN) && !empty;

	assign sts.func_run  = (func_q == FUNC_RUN);
	assign sts.full      = full;
	assign sts.empty     = empty;
	assign sts.slot_free = !valid_q[idx_q];
	assign sts.idx_last  = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign sts.out_busy  = out_busy;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= job.func;
			arr_q  <= job.arrival_time;
			bur_q  <= job.burst_time;
		end
	end

	// Job store
	sjft_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (do_add),
		.waddr(idx_q),
		.wdata({arr_q, bur_q}),
		.re   (cmd.step && (func_q == FUNC_RUN)),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign c_arr = rd_data[ENT_W-1:TIME_W];
	assign c_bur = rd_data[TIME_W-1:0];

	// Scan index and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cmp_en_s1 <= 1'b0;
		end else begin
			if (cmd.clr_scan) begin
				idx_q <= '0;
			end else if (cmd.step && !sts.idx_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			cmp_en_s1 <= cmd.step && (func_q == FUNC_RUN);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		cmp_v_s1   <= valid_q[idx_q];
	end

	// Compare the slot just read against both running bests
	assign arrived  = ({{(CLOCK_W - TIME_W){1'b0}}, c_arr} <= clock_q);
	assign e_better = !e_found_q || (c_arr < e_arr_q);
	assign s_better = arrived && (!s_found_q || (c_bur < s_bur_q) ||
		((c_bur == s_bur_q) && (c_arr < s_arr_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_found_q <= 1'b0;
			s_found_q <= 1'b0;
		end else if (cmd.clr_scan) begin
			e_found_q <= 1'b0;
			s_found_q <= 1'b0;
		end else if (cmp_en_s1 && cmp_v_s1) begin
			if (e_better) begin
				e_found_q <= 1'b1;
			end
			if (s_better) begin
				s_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en_s1 && cmp_v_s1) begin
			if (e_better) begin
				e_arr_q <= c_arr;
				e_bur_q <= c_bur;
				e_idx_q <= cmp_idx_s1;
			end
			if (s_better) begin
				s_arr_q <= c_arr;
				s_bur_q <= c_bur;
				s_idx_q <= cmp_idx_s1;
			end
		end
	end

	// Choose the job to run and the new completion clock
	assign use_s    = (clock_q != '0) && s_found_q;
	assign pick_arr = use_s ? s_arr_q : e_arr_q;
	assign pick_bur = use_s ? s_bur_q : e_bur_q;
	assign pick_idx = use_s ? s_idx_q : e_idx_q;
	assign sum_base = use_s ? clock_q : {{(CLOCK_W - TIME_W){1'b0}}, pick_arr};
	assign sum_full = {1'b0, sum_base} + {{(CLOCK_W + 1 - TIME_W){1'b0}}, pick_bur};
	assign new_clock = sum_full[CLOCK_W] ? '1 : sum_full[CLOCK_W-1:0];

	always_comb begin
		cnt_next = cnt_q;
		if (do_add) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (do_run) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	assign cnt_ext = 32'(cnt_next);

	// Update table state on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
			clock_q <= '0;
		end else begin
			cnt_q <= cnt_next;
			if (do_add) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (do_run) begin
				valid_q[pick_idx] <= 1'b0;
				clock_q           <= new_clock;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.ran_arrival <= do_run ? pick_arr : '0;
			res_q.ran_burst   <= do_run ? pick_bur : '0;
			res_q.finish_time <= do_run ? new_clock : clock_q;
			res_q.jobs_left   <= cnt_ext[LEFT_W-1:0];
			if (func_q == FUNC_ADD) begin
				res_q.status <= full ? ST_FULL : ST_ADDED;
			end else begin
				res_q.status <= empty ? ST_EMPTY : ST_RAN;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SJFT_ASSERT_NOW(a_cnt_matches_valid, 1'b1, $countones(valid_q) == int'(cnt_q), "job count out of step with valid bits")
	`SJFT_ASSERT_NEXT(a_commit_shows_result, cmd.commit, res_valid_q, "commit did not raise result valid")
	`SJFT_ASSERT_NOW(a_run_has_pick, do_run, e_found_q, "run commit without a candidate job")
	`SJFT_ASSERT_NOW(a_commit_not_blocked, cmd.commit, !out_busy, "commit while result is stalled")

endmodule

@@ rtl/core/sjft_ctrl.sv @@
module sjft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_stall,
	input  sjft_pkg::sjft_sts_t sts,
	output sjft_pkg::sjft_cmd_t cmd
);

	import sjft_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ADD_SCAN,
		S_RUN_SCAN,
		S_RUN_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign job_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.func_run && !sts.empty) begin
					cmd.clr_scan = 1'b1;
					state_d      = S_RUN_SCAN;
				end else if (!sts.func_run && !sts.full) begin
					cmd.clr_scan = 1'b1;
					state_d      = S_ADD_SCAN;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_ADD_SCAN: begin
				if (sts.slot_free) begin
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_RUN_SCAN: begin
				cmd.step = 1'b1;
				if (sts.idx_last) begin
					state_d = S_RUN_DRAIN;
				end
			end
			S_RUN_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ test/sjf_scheduler_table_test.sv @@
`timescale 1ns / 1ps

module sjf_scheduler_table_test;
	import sjft_pkg::*;

	localparam int DEPTH = 16;
	localparam int QUIET_LIMIT = 2000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      job_valid = 1'b0;
	logic      job_stall;
	sjft_in_t  job = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	sjft_out_t res;

	// Job table as the scheduler should hold it
	bit                 tbl_used[DEPTH];
	logic [TIME_W-1:0]  tbl_arrival[DEPTH];
	logic [TIME_W-1:0]  tbl_burst[DEPTH];
	logic [CLOCK_W-1:0] sched_clock = '0;
	int                 jobs_held = 0;

	sjft_in_t  job_backlog[$];
	sjft_out_t predicted_res[$];

	int fail_count = 0;
	int queued_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit wide_fields = 1'b0;
	int send_idle[4] = '{0, 64, 0, 33};
	int res_idle[4] = '{0, 0, 64, 33};

	sjf_scheduler_table #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.job(job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one accepted beat to the table and return the result it must give
	function automatic sjft_out_t schedule_job(sjft_in_t item);
		sjft_out_t r;
		int pick;
		int s;
		bit jump;
		logic [CLOCK_W:0] sum;
		r = '0;
		pick = -1;
		jump = 1'b1;
		if (item.func == FUNC_ADD) begin
			for (s = 0; s < DEPTH; s++) begin
				if (!tbl_used[s] && pick < 0)
					pick = s;
			end
			if (pick < 0) begin
				r.status = ST_FULL;
			end else begin
				tbl_used[pick] = 1'b1;
				tbl_arrival[pick] = item.arrival_time;
				tbl_burst[pick] = item.burst_time;
				jobs_held++;
				r.status = ST_ADDED;
			end
		end else begin
			// shortest burst among arrived jobs, earlier arrival then lower slot on ties
			if (sched_clock != 0) begin
				for (s = 0; s < DEPTH; s++) begin
					if (tbl_used[s] && {16'd0, tbl_arrival[s]} <= sched_clock) begin
						if (pick < 0 || tbl_burst[s] < tbl_burst[pick] ||
								(tbl_burst[s] == tbl_burst[pick] &&
								tbl_arrival[s] < tbl_arrival[pick]))
							pick = s;
					end
				end
				if (pick >= 0)
					jump = 1'b0;
			end
			// first run or idle: earliest arrival, lower slot on ties
			if (pick < 0) begin
				for (s = 0; s < DEPTH; s++) begin
					if (tbl_used[s] && (pick < 0 || tbl_arrival[s] < tbl_arrival[pick]))
						pick = s;
				end
			end
			if (pick < 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_RAN;
				r.ran_arrival = tbl_arrival[pick];
				r.ran_burst = tbl_burst[pick];
				if (jump)
					sum = {17'd0, tbl_arrival[pick]} + {17'd0, tbl_burst[pick]};
				else
					sum = {1'b0, sched_clock} + {17'd0, tbl_burst[pick]};
				sched_clock = sum[CLOCK_W] ? '1 : sum[CLOCK_W-1:0];
				tbl_used[pick] = 1'b0;
				if (jobs_held > 0)
					jobs_held--;
			end
		end
		r.finish_time = sched_clock;
		r.jobs_left = LEFT_W'(jobs_held);
		return r;
	endfunction

	function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	function automatic void push_job(logic func, logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur);
		sjft_in_t item;
		item.func = func;
		item.arrival_time = arr;
		item.burst_time = bur;
		job_backlog.push_back(item);
		queued_count++;
	endfunction

	// Mostly near the current clock so both arrived and future jobs show up
	function automatic logic [TIME_W-1:0] pick_arrival();
		int offset;
		longint near_clock;
		if (wide_fields && $urandom_range(1) == 1)
			return TIME_W'($urandom_range(16'hFFFF));
		if ($urandom_range(3) == 0)
			return TIME_W'($urandom_range(15));
		offset = $urandom_range(400);
		offset -= 150;
		near_clock = longint'(sched_clock) + offset;
		if (near_clock < 0)
			return '0;
		if (near_clock > 65535)
			return 16'hFFFF;
		return near_clock[TIME_W-1:0];
	endfunction

	// Keep bursts short unless wide fields are on, so the clock stays low for idle jumps
	function automatic logic [TIME_W-1:0] pick_burst();
		if (!wide_fields)
			return TIME_W'($urandom_range(31));
		case ($urandom_range(2))
			0: return TIME_W'($urandom_range(16'hFFFF));
			1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return TIME_W'($urandom_range(31));
		endcase
	endfunction

	task automatic wait_backlog();
		while (job_backlog.size() != 0)
			@(posedge clk);
	endtask

	// One batch: a run of adds then runs, or a short burst of noise
	task automatic queue_batch();
		int adds;
		int runs;
		int k;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 12))
				push_job(1'($urandom_range(1)), pick_arrival(), pick_burst());
		end else begin
			adds = ($urandom_range(3) == 0) ? $urandom_range(DEPTH + 2) : $urandom_range(1, 6);
			for (k = 0; k < adds; k++)
				push_job(FUNC_ADD, pick_arrival(), pick_burst());
			runs = $urandom_range(1, jobs_held + adds + 1);
			for (k = 0; k < runs; k++)
				push_job(FUNC_RUN, TIME_W'($urandom_range(16'hFFFF)),
					TIME_W'($urandom_range(16'hFFFF)));
		end
	endtask

	// Present the oldest pending job; predict it on acceptance
	always @(posedge clk) begin : drive_jobs
		bit fired;
		fired = arst_n && job_valid && !job_stall;
		if (fired) begin
			predicted_res.push_back(schedule_job(job));
			void'(job_backlog.pop_front());
		end
		if (arst_n && (fired || !job_valid)) begin
			if (job_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				job_valid <= 1'b1;
				job <= job_backlog[0];
			end else begin
				job_valid <= 1'b0;
			end
		end
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin : check_results
		sjft_out_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (predicted_res.size() == 0) begin
					$error("result beat with no job outstanding");
					fail_count++;
				end else begin
					want = predicted_res.pop_front();
					compare_field("status", 32'(want.status), 32'(res.status));
					compare_field("ran_arrival", 32'(want.ran_arrival), 32'(res.ran_arrival));
					compare_field("ran_burst", 32'(want.ran_burst), 32'(res.ran_burst));
					compare_field("finish_time", want.finish_time, res.finish_time);
					compare_field("jobs_left", 32'(want.jobs_left), 32'(res.jobs_left));
				end
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((job_valid && !job_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("sjf_scheduler_table regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase;
		int target;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, zero-length job at time zero, then first-run rule again
		push_job(FUNC_RUN, 16'h0000, 16'h0000);
		push_job(FUNC_ADD, 16'd0, 16'd0);
		push_job(FUNC_RUN, 16'h0000, 16'h0000);
		// earliest-arrival tie goes to the lower slot, then shortest arrived, then idle jumps
		push_job(FUNC_ADD, 16'd40, 16'd5);
		push_job(FUNC_ADD, 16'd7, 16'd9);
		push_job(FUNC_ADD, 16'd7, 16'd3);
		push_job(FUNC_ADD, 16'd100, 16'd1);
		repeat (4) push_job(FUNC_RUN, 16'hFFFF, 16'hFFFF);
		// equal bursts: earlier arrival, then lower slot; drain past empty
		push_job(FUNC_ADD, 16'd50, 16'd4);
		push_job(FUNC_ADD, 16'd60, 16'd4);
		push_job(FUNC_ADD, 16'd50, 16'd4);
		push_job(FUNC_ADD, 16'd30, 16'd6);
		repeat (5) push_job(FUNC_RUN, 16'h0000, 16'h0000);

		for (phase = 0; phase < 4; phase++) begin
			wait_backlog();
			send_idle_pct = send_idle[phase];
			stall_pct = res_idle[phase];
			wide_fields = (phase == 3);
			target = queued_count + 475;
			while (queued_count < target) begin
				wait_backlog();
				queue_batch();
			end
		end

		// drain the table, then a few wide add and run pairs
		wait_backlog();
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (jobs_held + 1) push_job(FUNC_RUN, 16'h0000, 16'h0000);
		repeat (4) begin
			push_job(FUNC_ADD, TIME_W'($urandom_range(16'hFFFF)),
				TIME_W'($urandom_range(16'hFFFF)));
			push_job(FUNC_RUN, 16'h0000, 16'h0000);
		end

		wait_backlog();
		while (predicted_res.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("sjf_scheduler_table regression: pass");
		else
			$display("sjf_scheduler_table regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sjft_pkg.sv
rtl/core/sjft_ram.sv
rtl/core/sjft_dpath.sv
rtl/core/sjft_ctrl.sv
rtl/core/sjf_scheduler_table.sv
test/sjf_scheduler_table_test.sv
